// ----- rtl/mfmt_pkg.sv -----
package mfmt_pkg;

    // fixed field widths
    localparam int unsigned ID_W     = 11;
    localparam int unsigned ANGLE_W  = 16;
    localparam int unsigned TURN_W   = 16;
    localparam int unsigned TOTAL_W  = 30;
    localparam int unsigned TEMP_W   = 8;
    localparam int unsigned OUT_IDX_W = 3;

    // reset value of the base identifier
    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd513;

    // half a turn in encoder counts, and log2 of counts per turn
    localparam logic signed [ANGLE_W-1:0] HALF_TURN = 16'sd4096;
    localparam int unsigned TURN_SHIFT = 13;

    // per-motor history kept in the state memory
    typedef struct packed {
        logic [ANGLE_W-1:0] prev_angle;
        logic [TURN_W-1:0]  revs;
        logic [ANGLE_W-1:0] offset;
    } mfmt_entry_t;

    localparam int unsigned ENTRY_W = $bits(mfmt_entry_t);

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } mfmt_state_t;

endpackage

// ----- rtl/mfmt_ram.sv -----
module mfmt_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mfmt_unwrap.sv -----
module mfmt_unwrap
    import mfmt_pkg::*;
(
    input  logic                      first,
    input  logic [ANGLE_W-1:0]        angle,
    input  mfmt_entry_t               rd_entry,
    output mfmt_entry_t               wr_entry,
    output logic signed [TOTAL_W-1:0] total
);

    logic signed [ANGLE_W-1:0] delta;
    logic                      turn_up;
    logic                      turn_down;
    logic [TURN_W-1:0]         revs_new;
    logic [TOTAL_W-1:0]        turns_scaled;
    logic [TOTAL_W-1:0]        angle_rel;

    // wrapped angle step since the previous frame
    always_comb begin
        delta     = $signed(angle - rd_entry.prev_angle);
        turn_up   = (delta <= -HALF_TURN);
        turn_down = (delta >= HALF_TURN);
    end

    // revolution count update
    always_comb begin
        if (first) begin
            revs_new = '0;
        end else if (turn_up) begin
            revs_new = rd_entry.revs + TURN_W'(1);
        end else if (turn_down) begin
            revs_new = rd_entry.revs - TURN_W'(1);
        end else begin
            revs_new = rd_entry.revs;
        end
    end

    // multi-turn angle relative to the zero offset
    always_comb begin
        turns_scaled = {revs_new[TURN_W-1], revs_new, {TURN_SHIFT{1'b0}}};
        angle_rel    = TOTAL_W'(angle) - TOTAL_W'(rd_entry.offset);
        if (first) begin
            total = '0;
        end else begin
            total = $signed(turns_scaled + angle_rel);
        end
    end

    // write-back entry
    always_comb begin
        wr_entry.prev_angle = angle;
        wr_entry.revs       = revs_new;
        wr_entry.offset     = first ? angle : rd_entry.offset;
    end

endmodule

// ----- rtl/motor_feedback_multiturn_tracker.sv -----
// Multi-turn angle tracker for a group of CAN motors.
//
// Input channel (s_valid/s_ready): one received frame per word, an 11-bit
// standard identifier and 8 payload bytes, byte 0 in the top bits. Frames
// whose identifier is base .. base+MOTOR_COUNT-1 produce one result word on
// the m_ channel; any other identifier is taken and dropped with no result.
// Configuration: cfg_wr_en writes cfg_wr_data into the base identifier.
//
// Each matching frame is one read-modify-write of its motor's entry in the
// state memory. The memory read is registered, so a frame is accepted in the
// idle state and its result is loaded into the output register from the
// lookup state once the output register is free; no new frame is taken until
// that load. Non-matching frames are taken in the idle state with no lookup.
//
// Reset clears the base identifier to 513 and marks every motor as waiting
// for its first frame; the memory needs no clearing pass. If the receiver
// stalls, the result waits in the output register; one more frame may be
// accepted and held at the memory read until the output register frees.
module motor_feedback_multiturn_tracker
    import mfmt_pkg::*;
#(
    parameter int unsigned MOTOR_COUNT = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [ID_W-1:0]           cfg_wr_data,
    // frame input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ID_W-1:0]           s_frame_id,
    input  logic [63:0]               s_payload,
    // result output
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_IDX_W-1:0]      m_motor_index,
    output logic [ANGLE_W-1:0]        m_encoder_angle,
    output logic signed [15:0]        m_motor_speed,
    output logic signed [15:0]        m_motor_current,
    output logic [TEMP_W-1:0]         m_motor_temperature,
    output logic signed [TURN_W-1:0]  m_turn_count,
    output logic signed [TOTAL_W-1:0] m_total_angle,
    output logic                      m_first_frame
);

    localparam int unsigned IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    mfmt_state_t state_reg, state_next;

    logic [ID_W-1:0]      base_id_reg;
    logic [MOTOR_COUNT-1:0] seen_reg;

    logic [ID_W-1:0]      id_diff;
    logic                 id_match;
    logic                 in_accept;
    logic                 out_load;
    logic                 ram_rd_en;
    logic                 ram_wr_en;

    // frame held across the memory read
    logic [IDX_W-1:0]     idx_reg;
    logic [OUT_IDX_W-1:0] oidx_reg;
    logic [ANGLE_W-1:0]   angle_reg;
    logic [15:0]          speed_reg;
    logic [15:0]          current_reg;
    logic [TEMP_W-1:0]    temp_reg;

    // output register
    logic                      m_valid_reg;
    logic [OUT_IDX_W-1:0]      m_index_reg;
    logic [ANGLE_W-1:0]        m_angle_reg;
    logic signed [15:0]        m_speed_reg;
    logic signed [15:0]        m_current_reg;
    logic [TEMP_W-1:0]         m_temp_reg;
    logic signed [TURN_W-1:0]  m_turns_reg;
    logic signed [TOTAL_W-1:0] m_total_reg;
    logic                      m_first_reg;

    mfmt_entry_t               rd_entry;
    mfmt_entry_t               wr_entry;
    logic signed [TOTAL_W-1:0] total;
    logic                      first;

    // identifier match against the configured base
    always_comb begin
        id_diff  = s_frame_id - base_id_reg;
        id_match = (s_frame_id >= base_id_reg) && (id_diff < ID_W'(MOTOR_COUNT));
    end

    assign in_accept = s_valid && s_ready;
    assign first     = !seen_reg[idx_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && id_match) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready  = 1'b1;
            ST_LOOKUP: out_load = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign ram_rd_en = in_accept && id_match;
    assign ram_wr_en = out_load;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_id_reg <= BASE_ID_RESET;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                base_id_reg <= cfg_wr_data;
            end
            if (ram_wr_en) begin
                seen_reg[idx_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // frame capture and field decode
    always_ff @(posedge aclk) begin
        if (ram_rd_en) begin
            idx_reg     <= id_diff[IDX_W-1:0];
            oidx_reg    <= id_diff[OUT_IDX_W-1:0];
            angle_reg   <= s_payload[63:48];
            speed_reg   <= s_payload[47:32];
            current_reg <= s_payload[31:16];
            temp_reg    <= s_payload[15:8];
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg   <= oidx_reg;
            m_angle_reg   <= angle_reg;
            m_speed_reg   <= $signed(speed_reg);
            m_current_reg <= $signed(current_reg);
            m_temp_reg    <= temp_reg;
            m_turns_reg   <= $signed(wr_entry.revs);
            m_total_reg   <= total;
            m_first_reg   <= first;
        end
    end

    // per-motor state memory
    mfmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MOTOR_COUNT)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (id_diff[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // angle unwrap
    mfmt_unwrap u_unwrap (
        .first    (first),
        .angle    (angle_reg),
        .rd_entry (rd_entry),
        .wr_entry (wr_entry),
        .total    (total)
    );

    assign m_valid             = m_valid_reg;
    assign m_motor_index       = m_index_reg;
    assign m_encoder_angle     = m_angle_reg;
    assign m_motor_speed       = m_speed_reg;
    assign m_motor_current     = m_current_reg;
    assign m_motor_temperature = m_temp_reg;
    assign m_turn_count        = m_turns_reg;
    assign m_total_angle       = m_total_reg;
    assign m_first_frame       = m_first_reg;

`ifndef SYNTHESIS
    // a write-back marks the motor as seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> seen_reg[$past(idx_reg)])
        else $error("motor not marked seen after write-back");

    // a loaded result is presented on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded result not presented");

    // a first frame reports zero turns and zero total angle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_first_frame) |-> (m_turn_count == '0 && m_total_angle == '0))
        else $error("first frame with nonzero turns or angle");

    // a frame for another identifier leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !id_match) |=> (state_reg == ST_IDLE))
        else $error("unmatched frame started a lookup");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfmt_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 6;
    localparam int MOTORS           = 8;
    localparam int ID_SPACE         = 1 << ID_W;
    localparam int TURN_STEP        = 4096;
    localparam int COUNTS_PER_TURN  = 8192;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int SPIN_STEPS       = 60;
    localparam int DRAIN_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 2000;

    // one received frame as it goes onto the input channel
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [63:0]     payload;
    } frame_t;

    // decoded feedback word for one motor
    typedef struct packed {
        logic [OUT_IDX_W-1:0]      motor_index;
        logic [ANGLE_W-1:0]        encoder_angle;
        logic signed [15:0]        motor_speed;
        logic signed [15:0]        motor_current;
        logic [TEMP_W-1:0]         motor_temperature;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [TOTAL_W-1:0] total_angle;
        logic                      first_frame;
    } feedback_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [ID_W-1:0]           cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [ID_W-1:0]           s_frame_id = '0;
    logic [63:0]               s_payload = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_IDX_W-1:0]      m_motor_index;
    logic [ANGLE_W-1:0]        m_encoder_angle;
    logic signed [15:0]        m_motor_speed;
    logic signed [15:0]        m_motor_current;
    logic [TEMP_W-1:0]         m_motor_temperature;
    logic signed [TURN_W-1:0]  m_turn_count;
    logic signed [TOTAL_W-1:0] m_total_angle;
    logic                      m_first_frame;

    // stimulus and expected feedback
    frame_t    pending_frames[$];
    feedback_t expected_feedback[$];
    frame_t    next_frame;
    feedback_t oldest_feedback;

    // tracker model state
    logic [ID_W-1:0]          base_id = BASE_ID_RESET;
    logic                     awaiting[MOTORS];
    logic [ANGLE_W-1:0]       last_angle[MOTORS];
    logic signed [TURN_W-1:0] turns[MOTORS];
    logic [ANGLE_W-1:0]       zero_at[MOTORS];

    // angle last put in the stimulus for each motor
    logic [ANGLE_W-1:0] gen_angle[MOTORS];

    int unsigned sender_gap_pct = 0;
    int unsigned receiver_gap_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    motor_feedback_multiturn_tracker #(
        .MOTOR_COUNT(MOTORS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_frame_id         (s_frame_id),
        .s_payload          (s_payload),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_motor_index      (m_motor_index),
        .m_encoder_angle    (m_encoder_angle),
        .m_motor_speed      (m_motor_speed),
        .m_motor_current    (m_motor_current),
        .m_motor_temperature(m_motor_temperature),
        .m_turn_count       (m_turn_count),
        .m_total_angle      (m_total_angle),
        .m_first_frame      (m_first_frame)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // unwrap the angle of one accepted frame and queue its feedback word
    task automatic track_frame(input logic [ID_W-1:0] id, input logic [63:0] pl);
        feedback_t          fb;
        int                 rel;
        logic signed [15:0] delta;
        rel = int'(id) - int'(base_id);
        if (rel < 0 || rel >= MOTORS)
            return;
        fb.motor_index       = rel[OUT_IDX_W-1:0];
        fb.encoder_angle     = pl[63:48];
        fb.motor_speed       = pl[47:32];
        fb.motor_current     = pl[31:16];
        fb.motor_temperature = pl[15:8];
        if (awaiting[rel]) begin
            zero_at[rel]     = fb.encoder_angle;
            turns[rel]       = '0;
            awaiting[rel]    = 1'b0;
            fb.first_frame   = 1'b1;
            fb.total_angle   = '0;
        end else begin
            // wrapped step since the last frame decides the turn direction
            delta = fb.encoder_angle - last_angle[rel];
            if (delta <= -TURN_STEP)
                turns[rel] = turns[rel] + 16'sd1;
            else if (delta >= TURN_STEP)
                turns[rel] = turns[rel] - 16'sd1;
            fb.first_frame = 1'b0;
            fb.total_angle = TOTAL_W'(int'(turns[rel]) * COUNTS_PER_TURN
                                      + int'(fb.encoder_angle) - int'(zero_at[rel]));
        end
        last_angle[rel] = fb.encoder_angle;
        fb.turn_count   = turns[rel];
        expected_feedback.push_back(fb);
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string field, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    function automatic logic [47:0] rnd48();
        return {16'($urandom), $urandom};
    endfunction

    task automatic push_frame(input logic [ID_W-1:0] id, input logic [63:0] pl);
        frame_t f;
        f.id = id;
        f.payload = pl;
        pending_frames.push_back(f);
    endtask

    // wait until every frame is taken and every word has come back
    task automatic drain_all();
        while (pending_frames.size() != 0 || s_valid || expected_feedback.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_base(input logic [ID_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_id = value;
    endtask

    // mostly frames for the tracked motors, with near misses and stray ids
    task automatic random_frames(input int count);
        int              i;
        int              k;
        int              pick;
        int              span;
        int              slot;
        int              id_int;
        logic [15:0]     prev;
        logic [15:0]     ang;
        logic [15:0]     jump;
        for (k = 0; k < MOTORS; k++)
            gen_angle[k] = last_angle[k];
        span = ID_SPACE - int'(base_id);
        if (span > MOTORS)
            span = MOTORS;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                slot = $urandom_range(span - 1);
                prev = gen_angle[slot];
                pick = $urandom_range(9);
                if (pick < 4) begin
                    ang = prev + 16'($urandom_range(8190)) - 16'd4095;
                end else if (pick < 6) begin
                    jump = $urandom_range(1) ? 16'd4096 : 16'd4095;
                    ang  = $urandom_range(1) ? prev + jump : prev - jump;
                end else if (pick < 8) begin
                    ang = 16'($urandom);
                end else if (pick == 8) begin
                    ang = prev;
                end else begin
                    ang = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                gen_angle[slot] = ang;
                push_frame(base_id + ID_W'(slot), {ang, rnd48()});
            end else if (pick < 90) begin
                // just below the range, or just past it with wrap at the top
                if ($urandom_range(1) && base_id != '0)
                    id_int = int'(base_id) - 1;
                else
                    id_int = (int'(base_id) + span + $urandom_range(MOTORS - 1)) % ID_SPACE;
                push_frame(ID_W'(id_int), {$urandom, $urandom});
            end else begin
                push_frame(ID_W'($urandom_range(ID_SPACE - 1)), {$urandom, $urandom});
            end
        end
    endtask

    task automatic run_phase(input logic [ID_W-1:0] base, input int unsigned s_gap,
                             input int unsigned r_gap);
        sender_gap_pct   = s_gap;
        receiver_gap_pct = r_gap;
        set_base(base);
        random_frames(RANDOM_PER_PHASE);
        drain_all();
    endtask

    // turn one motor down through many revolutions, then back up by one
    task automatic spin_turns(input int slot, input int down_steps);
        logic [15:0]     ang;
        logic [ID_W-1:0] id;
        id  = base_id + ID_W'(slot);
        ang = last_angle[slot];
        if (awaiting[slot])
            push_frame(id, {ang, rnd48()});
        repeat (down_steps) begin
            ang = ang + 16'($urandom_range(32767, TURN_STEP));
            push_frame(id, {ang, rnd48()});
        end
        ang = ang - 16'($urandom_range(32768, TURN_STEP));
        push_frame(id, {ang, rnd48()});
        drain_all();
    endtask

    // input channel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_frame(s_frame_id, s_payload);
            if (!s_valid || s_ready) begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    next_frame = pending_frames.pop_front();
                    s_valid    <= 1'b1;
                    s_frame_id <= next_frame.id;
                    s_payload  <= next_frame.payload;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result channel monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_feedback.size() == 0) begin
                    log_mismatch("feedback word with no frame waiting for it");
                end else begin
                    oldest_feedback = expected_feedback.pop_front();
                    compare_field("motor_index", m_motor_index, oldest_feedback.motor_index);
                    compare_field("encoder_angle", m_encoder_angle,
                                  oldest_feedback.encoder_angle);
                    compare_field("motor_speed", m_motor_speed, oldest_feedback.motor_speed);
                    compare_field("motor_current", m_motor_current,
                                  oldest_feedback.motor_current);
                    compare_field("motor_temperature", m_motor_temperature,
                                  oldest_feedback.motor_temperature);
                    compare_field("turn_count", m_turn_count, oldest_feedback.turn_count);
                    compare_field("total_angle", m_total_angle, oldest_feedback.total_angle);
                    compare_field("first_frame", m_first_frame, oldest_feedback.first_frame);
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // test sequence
    initial begin
        int          k;
        logic [10:0] b;
        for (k = 0; k < MOTORS; k++) begin
            awaiting[k]   = 1'b1;
            last_angle[k] = '0;
            turns[k]      = '0;
            zero_at[k]    = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset base
        sender_gap_pct   = 12;
        receiver_gap_pct = 69;
        b = BASE_ID_RESET;
        push_frame(b, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(b, {16'h0000, 16'h8000, 16'h7FFF, 8'h00, 8'hA5});
        push_frame(b, {16'h1000, rnd48()});
        push_frame(b, {16'h0000, rnd48()});
        push_frame(b, {16'h0FFF, rnd48()});
        push_frame(b, {16'h0000, rnd48()});
        push_frame(b, {16'h8000, rnd48()});
        push_frame(b, {16'h0000, rnd48()});
        push_frame(b, {16'h7FFF, rnd48()});
        // identifiers outside the motor range
        push_frame(b - 11'd1, {$urandom, $urandom});
        push_frame(b + 11'd8, {$urandom, $urandom});
        push_frame(11'd0, {$urandom, $urandom});
        push_frame(11'h7FF, {$urandom, $urandom});
        // first frame of every other motor
        for (k = 1; k < MOTORS; k++)
            push_frame(b + 11'(k), {16'(k * 9000), rnd48()});
        push_frame(b + 11'd7, {16'h0000, rnd48()});
        random_frames(RANDOM_PER_PHASE);
        drain_all();

        // base settings, extremes included
        run_phase(11'd0, 12, 69);
        run_phase(11'h7FF, 69, 12);
        run_phase(11'd2044, 69, 12);
        run_phase(11'($urandom_range(ID_SPACE - 1)), 0, 0);
        run_phase(11'd1365, 0, 0);
        spin_turns(0, SPIN_STEPS);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mfmt_pkg.sv
rtl/mfmt_ram.sv
rtl/mfmt_unwrap.sv
rtl/motor_feedback_multiturn_tracker.sv
tb/sv/tb.sv
